// ===== hdl/itp_pkg.sv =====
// Shared types, codes and the precedence table of the infix-to-postfix converter.
`default_nettype none
package itp_pkg;

  // token classes (input tuser)
  localparam logic [2:0] TOK_OPERAND = 3'd0;
  localparam logic [2:0] TOK_LPAREN  = 3'd1;
  localparam logic [2:0] TOK_RPAREN  = 3'd2;
  localparam logic [2:0] TOK_OPER    = 3'd3;
  localparam logic [2:0] TOK_END     = 3'd4;

  // result kinds (output tuser)
  localparam logic [1:0] KIND_OPERAND = 2'd0;
  localparam logic [1:0] KIND_OPER    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MISMATCH = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // operator codes that matter to the control
  localparam logic [3:0] OP_POW     = 4'd12;
  localparam logic [3:0] OP_MAX     = 4'd12;
  localparam logic [3:0] PAREN_MARK = 4'd15;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // command broadcast to every stack cell
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [3:0] push_val;
  } stk_cmd_t;

  function automatic logic [2:0] prec(input logic [3:0] code);
    logic [2:0] p;
    case (code)
      4'd0:                 p = 3'd1;
      4'd1:                 p = 3'd2;
      4'd2, 4'd3:           p = 3'd3;
      4'd4, 4'd5, 4'd6, 4'd7: p = 3'd4;
      4'd8, 4'd9:           p = 3'd5;
      4'd10, 4'd11:         p = 3'd6;
      4'd12:                p = 3'd7;
      default:              p = 3'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/itp_cell.sv =====
// One entry of the shifting operator stack.
`default_nettype none
module itp_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire itp_pkg::stk_cmd_t cmd,
  input  wire logic [3:0]       abv_val,  // neighbor nearer the top (or push data)
  input  wire logic             abv_occ,
  input  wire logic [3:0]       blw_val,  // neighbor nearer the bottom
  input  wire logic             blw_occ,
  output logic      [3:0]       val,
  output logic                  occ
);

  logic [3:0] val_r, val_nxt;
  logic       occ_r, occ_nxt;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (cmd.clear) begin
      occ_nxt = 1'b0;
    end else if (cmd.push) begin
      val_nxt = abv_val;
      occ_nxt = abv_occ;
    end else if (cmd.pop) begin
      val_nxt = blw_val;
      occ_nxt = blw_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign occ = occ_r;

endmodule
`default_nettype wire

// ===== hdl/infix_to_postfix_converter.sv =====
// Shunting-yard infix-to-postfix converter: control and a row of stack cells.
//
//  channel | dir | tvalid/tready | tuser       | tdata (low bit up)                | tlast
//  --------+-----+---------------+-------------+-----------------------------------+------
//  in_     | in  | request       | token class | operator_code, operand_handle     | -
//  out_    | out | request       | result kind | out_operator, out_operand, error  | last
//
// Operand, left paren and ignored tokens are handled on acceptance. Right
// paren, operator and end tokens start a pop loop that ends with a push, a
// mark pop, an error or, for end on an empty stack, a return to idle; it
// runs one entry per cycle through cell 0 while the output register is free.
// Synchronous active-low reset empties all cells at once (occupancy bits),
// clears skip mode and drops out_tvalid. A stalled output holds the result
// register; the controller waits and accepts nothing until it drains.
`default_nettype none
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH  = 32,
  parameter int OPERAND_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // slave side
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // [3:0] operator_code, [OPERAND_BITS+3:4] operand_handle, zero pad
  input  wire logic [((OPERAND_BITS+4+7)/8)*8-1:0]    in_tdata,
  // [2:0] op (token class)
  input  wire logic [2:0]                             in_tuser,
  // master side
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // [3:0] out_operator, [OPERAND_BITS+3:4] out_operand,
  // [OPERAND_BITS+5:OPERAND_BITS+4] error_code, zero pad
  output logic      [((OPERAND_BITS+6+7)/8)*8-1:0]    out_tdata,
  // [1:0] out_kind
  output logic      [1:0]                             out_tuser,
  output logic                                        out_tlast
);

  localparam int OUT_W = ((OPERAND_BITS + 6 + 7) / 8) * 8;

  // ---------------------------------------------------------------- stack row
  itp_pkg::stk_cmd_t stk_cmd;
  logic [3:0]             cell_val [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] cell_occ;
  logic [3:0]             abv_val  [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] abv_occ;
  logic [3:0]             blw_val  [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] blw_occ;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign abv_val[i] = stk_cmd.push_val;
      assign abv_occ[i] = 1'b1;
    end else begin : g_mid
      assign abv_val[i] = cell_val[i-1];
      assign abv_occ[i] = cell_occ[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign blw_val[i] = 4'd0;
      assign blw_occ[i] = 1'b0;
    end else begin : g_body
      assign blw_val[i] = cell_val[i+1];
      assign blw_occ[i] = cell_occ[i+1];
    end

    itp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (stk_cmd),
      .abv_val (abv_val[i]),
      .abv_occ (abv_occ[i]),
      .blw_val (blw_val[i]),
      .blw_occ (blw_occ[i]),
      .val     (cell_val[i]),
      .occ     (cell_occ[i])
    );
  end

  // top two entries, as the pop loop sees them
  logic [3:0] top_val, nxt_val;
  logic       top_occ, nxt_occ, full;
  assign top_val = cell_val[0];
  assign top_occ = cell_occ[0];
  assign nxt_val = cell_val[1];
  assign nxt_occ = cell_occ[1];
  assign full    = cell_occ[STACK_DEPTH-1];

  // ---------------------------------------------------------------- control
  itp_pkg::state_t state_r, state_nxt;
  logic       skip_r, skip_nxt;
  logic [2:0] tok_op_r, tok_op_nxt;
  logic [3:0] tok_code_r, tok_code_nxt;

  // output register
  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic [3:0]              out_oper_r;
  logic [OPERAND_BITS-1:0] out_hand_r;
  logic [1:0]              out_err_r;
  logic                    out_last_r;

  // result produced this cycle
  logic                    emit;
  logic [1:0]              e_kind;
  logic [3:0]              e_oper;
  logic [OPERAND_BITS-1:0] e_hand;
  logic [1:0]              e_err;
  logic                    e_last;

  logic [2:0]              in_op;
  logic [3:0]              in_code;
  logic [OPERAND_BITS-1:0] in_hand;
  logic                    slot;      // output register free this cycle
  logic                    in_accept;
  logic [2:0]              cur_prec;
  logic                    top_pops, nxt_pops;

  assign in_op     = in_tuser;
  assign in_code   = in_tdata[3:0];
  assign in_hand   = in_tdata[OPERAND_BITS+3:4];
  assign slot      = !out_valid_r || out_tready;
  assign in_tready = (state_r == itp_pkg::ST_IDLE) && slot;
  assign in_accept = in_tvalid && in_tready;

  // an incoming operator pops higher precedence, and equal unless it is pow
  assign cur_prec = itp_pkg::prec(tok_code_r);
  assign top_pops = (itp_pkg::prec(top_val) > cur_prec) ||
                    ((itp_pkg::prec(top_val) == cur_prec) && (tok_code_r != itp_pkg::OP_POW));
  assign nxt_pops = (itp_pkg::prec(nxt_val) > cur_prec) ||
                    ((itp_pkg::prec(nxt_val) == cur_prec) && (tok_code_r != itp_pkg::OP_POW));

  always_comb begin
    state_nxt    = state_r;
    skip_nxt     = skip_r;
    tok_op_nxt   = tok_op_r;
    tok_code_nxt = tok_code_r;
    stk_cmd      = '0;
    emit         = 1'b0;
    e_kind       = itp_pkg::KIND_OPERAND;
    e_oper       = 4'd0;
    e_hand       = '0;
    e_err        = itp_pkg::ERR_NONE;
    e_last       = 1'b0;

    case (state_r)
      itp_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (skip_r) begin
            if (in_op == itp_pkg::TOK_END) begin
              skip_nxt = 1'b0;
            end
          end else begin
            case (in_op)
              itp_pkg::TOK_OPERAND: begin
                emit   = 1'b1;
                e_kind = itp_pkg::KIND_OPERAND;
                e_hand = in_hand;
                e_last = 1'b1;
              end
              itp_pkg::TOK_LPAREN: begin
                if (full) begin
                  emit          = 1'b1;
                  e_kind        = itp_pkg::KIND_ERROR;
                  e_err         = itp_pkg::ERR_OVERFLOW;
                  e_last        = 1'b1;
                  stk_cmd.clear = 1'b1;
                  skip_nxt      = 1'b1;
                end else begin
                  stk_cmd.push     = 1'b1;
                  stk_cmd.push_val = itp_pkg::PAREN_MARK;
                end
              end
              itp_pkg::TOK_RPAREN, itp_pkg::TOK_END: begin
                tok_op_nxt = in_op;
                state_nxt  = itp_pkg::ST_POP;
              end
              itp_pkg::TOK_OPER: begin
                if (in_code <= itp_pkg::OP_MAX) begin
                  tok_op_nxt   = in_op;
                  tok_code_nxt = in_code;
                  state_nxt    = itp_pkg::ST_POP;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      itp_pkg::ST_POP: begin
        if (slot) begin
          case (tok_op_r)
            itp_pkg::TOK_RPAREN: begin
              if (!top_occ) begin
                // no matching left paren
                emit          = 1'b1;
                e_kind        = itp_pkg::KIND_ERROR;
                e_err         = itp_pkg::ERR_MISMATCH;
                e_last        = 1'b1;
                stk_cmd.clear = 1'b1;
                skip_nxt      = 1'b1;
                state_nxt     = itp_pkg::ST_IDLE;
              end else if (top_val == itp_pkg::PAREN_MARK) begin
                stk_cmd.pop = 1'b1;
                state_nxt   = itp_pkg::ST_IDLE;
              end else begin
                emit        = 1'b1;
                e_kind      = itp_pkg::KIND_OPER;
                e_oper      = top_val;
                e_last      = nxt_occ && (nxt_val == itp_pkg::PAREN_MARK);
                stk_cmd.pop = 1'b1;
              end
            end
            itp_pkg::TOK_END: begin
              if (!top_occ) begin
                state_nxt = itp_pkg::ST_IDLE;
              end else if (top_val == itp_pkg::PAREN_MARK) begin
                // left paren left open: error, but no skip
                emit          = 1'b1;
                e_kind        = itp_pkg::KIND_ERROR;
                e_err         = itp_pkg::ERR_MISMATCH;
                e_last        = 1'b1;
                stk_cmd.clear = 1'b1;
                state_nxt     = itp_pkg::ST_IDLE;
              end else begin
                emit        = 1'b1;
                e_kind      = itp_pkg::KIND_OPER;
                e_oper      = top_val;
                e_last      = !nxt_occ;
                stk_cmd.pop = 1'b1;
              end
            end
            default: begin
              // binary operator
              if (top_occ && (top_val != itp_pkg::PAREN_MARK) && top_pops) begin
                emit        = 1'b1;
                e_kind      = itp_pkg::KIND_OPER;
                e_oper      = top_val;
                e_last      = !(nxt_occ && (nxt_val != itp_pkg::PAREN_MARK) && nxt_pops);
                stk_cmd.pop = 1'b1;
              end else if (full) begin
                emit          = 1'b1;
                e_kind        = itp_pkg::KIND_ERROR;
                e_err         = itp_pkg::ERR_OVERFLOW;
                e_last        = 1'b1;
                stk_cmd.clear = 1'b1;
                skip_nxt      = 1'b1;
                state_nxt     = itp_pkg::ST_IDLE;
              end else begin
                stk_cmd.push     = 1'b1;
                stk_cmd.push_val = tok_code_r;
                state_nxt        = itp_pkg::ST_IDLE;
              end
            end
          endcase
        end
      end

      default: begin
        state_nxt = itp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itp_pkg::ST_IDLE;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      skip_r  <= skip_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    tok_op_r   <= tok_op_nxt;
    tok_code_r <= tok_code_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_oper_r <= e_oper;
      out_hand_r <= e_hand;
      out_err_r  <= e_err;
      out_last_r <= e_last;
    end
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    out_tdata                                 = {OUT_W{1'b0}};
    out_tdata[3:0]                            = out_oper_r;
    out_tdata[OPERAND_BITS+3:4]               = out_hand_r;
    out_tdata[OPERAND_BITS+5:OPERAND_BITS+4]  = out_err_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
